FILE: rtl/bitmap_set_engine_assert.svh
// Assertion macros shared by the bitmap set engine.
`ifndef BITMAP_SET_ENGINE_ASSERT_SVH
`define BITMAP_SET_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap set engine: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap set engine: next-cycle check failed");

`endif

FILE: rtl/bse_pkg.sv
`default_nettype none

package bse_pkg;

    // Default geometry of the bit store.
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_NUM_WORDS = 32;

    // Fixed field widths of the transactions.
    localparam int KIND_W  = 3;
    localparam int POS_W   = 11;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int MEMB_W  = 2;

    // Position that starts a next-after search at member zero.
    localparam logic signed [POS_W-1:0] POS_BEFORE_FIRST = -11'sd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_TEST   = 3'd2,
        KIND_TAKE   = 3'd3,
        KIND_NEXT   = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [MEMB_W-1:0] {
        MEMB_EMPTY  = 2'd0,
        MEMB_SINGLE = 2'd1,
        MEMB_MANY   = 2'd2
    } t_membership;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    // Operation context handed to the head unit for the word passing it.
    typedef struct packed {
        t_kind                     kind;
        logic signed [POS_W-1:0]   position;
        logic                      found_before;
    } t_head_ctl;

    // What the head unit found in the word passing it.
    typedef struct packed {
        logic               is_member;
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               count_up;
        logic               count_down;
    } t_head_res;

endpackage

`default_nettype wire

FILE: rtl/bse_cell.sv
`default_nettype none

module bse_cell #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_shift,
    input  wire logic [WORD_BITS-1:0] i_word,
    output logic      [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;

    // One word of the set; it takes its neighbor's word on every shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: rtl/bse_head.sv
`default_nettype none

module bse_head #(
    parameter int WORD_BITS = 32,
    parameter int BASE_W    = 11
) (
    input  wire bse_pkg::t_head_ctl    i_ctl,
    input  wire logic [BASE_W-1:0]     i_base,
    input  wire logic [WORD_BITS-1:0]  i_word,
    output logic      [WORD_BITS-1:0]  o_word,
    output bse_pkg::t_head_res         o_res
);
    import bse_pkg::*;

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int DIFF_W = ((BASE_W > POS_W) ? BASE_W : POS_W) + 2;
    localparam int SUM_W  = (BASE_W > INDEX_W) ? BASE_W : INDEX_W;
    localparam logic signed [DIFF_W-1:0] ZERO_S = '0;
    localparam logic signed [DIFF_W-1:0] ONE_S  = DIFF_W'(1);
    localparam logic signed [DIFF_W-1:0] WB_S   = DIFF_W'(WORD_BITS);

    logic signed [DIFF_W-1:0] pos_ext;
    logic signed [DIFF_W-1:0] base_ext;
    logic signed [DIFF_W-1:0] diff_pos;
    logic signed [DIFF_W-1:0] diff_start;
    logic                     hit;
    logic [WORD_BITS-1:0]     bit_sel;
    logic [WORD_BITS-1:0]     next_mask;
    logic                     scan_on;
    logic [WORD_BITS-1:0]     cand;
    logic [WORD_BITS-1:0]     low_onehot;
    logic [BIT_W-1:0]         low_bit;
    logic                     any_cand;
    logic [SUM_W-1:0]         index_sum;

    // Offsets of the position and of the search start inside this word.
    assign pos_ext    = DIFF_W'(i_ctl.position);
    assign base_ext   = $signed({{(DIFF_W-BASE_W){1'b0}}, i_base});
    assign diff_pos   = pos_ext - base_ext;
    assign diff_start = diff_pos + ONE_S;
    assign hit        = (diff_pos >= ZERO_S) && (diff_pos < WB_S);
    assign bit_sel    = hit ? ({{(WORD_BITS-1){1'b0}}, 1'b1} << diff_pos[BIT_W-1:0]) : '0;

    // Bits at or above the search start of a next-after operation.
    always_comb begin
        if (diff_start <= ZERO_S) begin
            next_mask = '1;
        end else if (diff_start >= WB_S) begin
            next_mask = '0;
        end else begin
            next_mask = {WORD_BITS{1'b1}} << diff_start[BIT_W-1:0];
        end
    end

    // Candidates for the lowest-member search, only until one is found.
    always_comb begin
        scan_on = 1'b0;
        cand    = '0;
        case (i_ctl.kind)
            KIND_TAKE: begin
                scan_on = !i_ctl.found_before;
                cand    = i_word;
            end
            KIND_NEXT: begin
                scan_on = !i_ctl.found_before && (i_ctl.position >= POS_BEFORE_FIRST);
                cand    = i_word & next_mask;
            end
            default: begin
                scan_on = 1'b0;
                cand    = '0;
            end
        endcase
    end

    // Isolate the lowest candidate bit and encode its place.
    assign low_onehot = cand & (~cand + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign any_cand   = scan_on && (|cand);

    always_comb begin
        low_bit = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            for (int k = 0; k < BIT_W; k++) begin
                if (((j >> k) & 1) == 1) begin
                    low_bit[k] = low_bit[k] | low_onehot[j];
                end
            end
        end
    end

    assign index_sum = SUM_W'(i_base) + SUM_W'(low_bit);

    // Word update and status for the operation in progress.
    always_comb begin
        o_word           = i_word;
        o_res.is_member  = 1'b0;
        o_res.found      = 1'b0;
        o_res.index      = index_sum[INDEX_W-1:0];
        o_res.count_up   = 1'b0;
        o_res.count_down = 1'b0;
        case (i_ctl.kind)
            KIND_ADD: begin
                o_word         = i_word | bit_sel;
                o_res.count_up = hit && !(|(i_word & bit_sel));
            end
            KIND_DELETE: begin
                o_word           = i_word & ~bit_sel;
                o_res.count_down = |(i_word & bit_sel);
            end
            KIND_TEST: begin
                o_res.is_member = |(i_word & bit_sel);
            end
            KIND_TAKE: begin
                if (any_cand) begin
                    o_word           = i_word & ~low_onehot;
                    o_res.found      = 1'b1;
                    o_res.count_down = 1'b1;
                end
            end
            KIND_NEXT: begin
                o_res.found = any_cand;
            end
            KIND_CLEAR: begin
                o_word = '0;
            end
            default: begin
                o_word = i_word;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bitmap_set_engine.sv
// A result is registered after the whole word ring has turned past the single head unit.
// A new transaction is taken only once the result of the last one has been loaded into the
// result register, so each operation holds the engine for one full turn of the word ring.
// Reset (synchronous, active low) empties the set, zeroes the member count and
// drops any pending result; a transaction can be accepted as soon as reset is released.
`default_nettype none

`include "bitmap_set_engine_assert.svh"

module bitmap_set_engine #(
    parameter int WORD_BITS = bse_pkg::DEF_WORD_BITS,
    parameter int NUM_WORDS = bse_pkg::DEF_NUM_WORDS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic        [bse_pkg::KIND_W-1:0]   i_kind,
    input  wire logic signed [bse_pkg::POS_W-1:0]    i_position,
    output logic                                     o_stall,
    output logic                                     o_valid,
    output logic                                     o_is_member,
    output logic                                     o_found,
    output logic             [bse_pkg::INDEX_W-1:0]  o_member_index,
    output logic                                     o_error,
    output logic             [bse_pkg::COUNT_W-1:0]  o_member_count,
    output logic             [bse_pkg::MEMB_W-1:0]   o_membership,
    input  wire logic                                i_stall
);
    import bse_pkg::*;

    localparam int CAPACITY = WORD_BITS * NUM_WORDS;
    localparam int BASE_W   = $clog2(CAPACITY + 1);
    localparam int STEP_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_X_W  = (BASE_W > COUNT_W) ? BASE_W : COUNT_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_WORDS - 1);

    t_state                r_state;
    t_state                n_state;
    t_kind                 r_kind;
    logic signed [POS_W-1:0] r_position;
    logic [STEP_W-1:0]     r_step;
    logic [BASE_W-1:0]     r_base;
    logic [BASE_W-1:0]     r_count;
    logic                  r_is_member;
    logic                  r_found;
    logic [INDEX_W-1:0]    r_index;
    logic                  r_error;
    logic                  r_out_valid;
    logic                  r_out_is_member;
    logic                  r_out_found;
    logic [INDEX_W-1:0]    r_out_index;
    logic                  r_out_error;
    logic [COUNT_W-1:0]    r_out_count;
    logic [MEMB_W-1:0]     r_out_membership;

    logic                  w_in_accept;
    logic                  w_shift;
    logic                  w_load;
    logic [WORD_BITS-1:0]  w_cell [NUM_WORDS];
    logic [WORD_BITS-1:0]  w_head_new;
    t_head_ctl             w_ctl;
    t_head_res             w_res;
    logic [CNT_X_W-1:0]    w_count_x;
    t_membership           w_membership;

    // Ring of word cells; the head word goes through the head unit and back to the tail.
    for (genvar gi = 0; gi < NUM_WORDS; gi++) begin : g_cell
        logic [WORD_BITS-1:0] feed;
        if (gi == NUM_WORDS - 1) begin : g_tail
            assign feed = w_head_new;
        end else begin : g_link
            assign feed = w_cell[gi+1];
        end
        bse_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_word  (feed),
            .o_word  (w_cell[gi])
        );
    end

    assign w_ctl.kind         = r_kind;
    assign w_ctl.position     = r_position;
    assign w_ctl.found_before = r_found;

    bse_head #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (BASE_W)
    ) u_head (
        .i_ctl  (w_ctl),
        .i_base (r_base),
        .i_word (w_cell[0]),
        .o_word (w_head_new),
        .o_res  (w_res)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall = 1'b1;
        w_shift = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_RUN: begin
                w_shift = 1'b1;
            end
            ST_FINISH: begin
                w_load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign w_in_accept = i_valid && !o_stall;

    // Membership class and output width of the running count.
    assign w_count_x = CNT_X_W'(r_count);
    always_comb begin
        if (r_count == '0) begin
            w_membership = MEMB_EMPTY;
        end else if (r_count == BASE_W'(1)) begin
            w_membership = MEMB_SINGLE;
        end else begin
            w_membership = MEMB_MANY;
        end
    end

    // Control state and the member count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_accept && (t_kind'(i_kind) == KIND_CLEAR)) begin
                r_count <= '0;
            end else if (w_shift && w_res.count_up) begin
                r_count <= r_count + BASE_W'(1);
            end else if (w_shift && w_res.count_down) begin
                r_count <= r_count - BASE_W'(1);
            end
        end
    end

    // Operation context and the status gathered over the turn of the ring.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_kind      <= t_kind'(i_kind);
            r_position  <= i_position;
            r_step      <= '0;
            r_base      <= '0;
            r_is_member <= 1'b0;
            r_found     <= 1'b0;
            r_index     <= '0;
            r_error     <= i_position[POS_W-1] && ((t_kind'(i_kind) == KIND_ADD)
                           || (t_kind'(i_kind) == KIND_DELETE)
                           || (t_kind'(i_kind) == KIND_TEST));
        end else if (w_shift) begin
            r_step      <= r_step + STEP_W'(1);
            r_base      <= r_base + BASE_W'(WORD_BITS);
            r_is_member <= r_is_member | w_res.is_member;
            if (w_res.found) begin
                r_found <= 1'b1;
                r_index <= w_res.index;
            end
        end
    end

    // Result register; it holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_is_member  <= r_is_member;
            r_out_found      <= r_found;
            r_out_index      <= r_index;
            r_out_error      <= r_error;
            r_out_count      <= w_count_x[COUNT_W-1:0];
            r_out_membership <= w_membership;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_member    = r_out_is_member;
    assign o_found        = r_out_found;
    assign o_member_index = r_out_index;
    assign o_error        = r_out_error;
    assign o_member_count = r_out_count;
    assign o_membership   = r_out_membership;

    // An accepted transaction starts a turn of the ring at the first word.
    `BSE_ASSERT_NEXT(a_start_turn, i_clk, i_rst_n, w_in_accept, (r_state == ST_RUN) && (r_step == '0) && (r_base == '0))
    // The turn ends after the last word has passed the head unit.
    `BSE_ASSERT_NEXT(a_end_turn, i_clk, i_rst_n, (r_state == ST_RUN) && (r_step == LAST_STEP), r_state == ST_FINISH)
    // The member count can never pass the capacity of the store.
    `BSE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= BASE_W'(CAPACITY))
    // The membership class agrees with the reported count.
    `BSE_ASSERT_NOW(a_class_count, i_clk, i_rst_n, o_valid, (o_membership == MEMB_EMPTY) == (o_member_count == '0))
    // A result with nothing found reports member index zero.
    `BSE_ASSERT_NOW(a_index_zero, i_clk, i_rst_n, o_valid && !o_found, o_member_index == '0)

endmodule

`default_nettype wire

FILE: tb/sv/bitmap_set_engine_test.sv
`timescale 1ns / 100ps

module bitmap_set_engine_test;
    import bse_pkg::*;

    localparam int CAPACITY = DEF_WORD_BITS * DEF_NUM_WORDS;
    localparam int LATENCY = DEF_NUM_WORDS + 2;
    localparam int QUIET_LIMIT = 1000;

    // Kind codes that the block treats as no operation.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Status of the set as reported for one transaction.
    typedef struct packed {
        logic               is_member;
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               error;
        logic [COUNT_W-1:0] count;
        logic [MEMB_W-1:0]  membership;
    } t_set_status;

    // Mirror of the bit store; predicts the status of every accepted operation.
    class t_bitmap_mirror;
        bit [CAPACITY-1:0] members;
        t_set_status       expected_status[$];
        int                failures;

        function new();
            members = '0;
            failures = 0;
        endfunction

        function int outstanding();
            return expected_status.size();
        endfunction

        // Lowest member at or above start, or -1 when there is none.
        function int lowest_from(int start);
            for (int m = start; m < CAPACITY; m++) begin
                if (members[m]) begin
                    return m;
                end
            end
            return -1;
        endfunction

        function void note_op(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] pos);
            t_set_status st;
            int p;
            int hit;
            int n;
            st = '0;
            p = pos;
            case (kind)
                KIND_ADD, KIND_DELETE, KIND_TEST: begin
                    if (p < 0) begin
                        st.error = 1'b1;
                    end else if (p < CAPACITY) begin
                        if (kind == KIND_ADD) begin
                            members[p] = 1'b1;
                        end else if (kind == KIND_DELETE) begin
                            members[p] = 1'b0;
                        end else begin
                            st.is_member = members[p];
                        end
                    end
                end
                KIND_TAKE: begin
                    hit = lowest_from(0);
                    if (hit >= 0) begin
                        st.found = 1'b1;
                        st.index = hit[INDEX_W-1:0];
                        members[hit] = 1'b0;
                    end
                end
                KIND_NEXT: begin
                    // Positions below the start marker find nothing.
                    if (p >= -1) begin
                        hit = lowest_from(p + 1);
                        if (hit >= 0) begin
                            st.found = 1'b1;
                            st.index = hit[INDEX_W-1:0];
                        end
                    end
                end
                KIND_CLEAR: begin
                    members = '0;
                end
                default: begin
                end
            endcase
            n = $countones(members);
            st.count = n[COUNT_W-1:0];
            st.membership = (n == 0) ? MEMB_EMPTY : (n == 1) ? MEMB_SINGLE : MEMB_MANY;
            expected_status.push_back(st);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                failures++;
            end
        endfunction

        function void check_status(t_set_status got);
            t_set_status want;
            if (expected_status.size() == 0) begin
                $error("result transaction with no operation pending");
                failures++;
                return;
            end
            want = expected_status.pop_front();
            compare("is_member", 16'(want.is_member), 16'(got.is_member));
            compare("found", 16'(want.found), 16'(got.found));
            compare("member_index", 16'(want.index), 16'(got.index));
            compare("error", 16'(want.error), 16'(got.error));
            compare("member_count", 16'(want.count), 16'(got.count));
            compare("membership", 16'(want.membership), 16'(got.membership));
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic [KIND_W-1:0]         i_kind;
    logic signed [POS_W-1:0]   i_position;
    logic                      i_stall;
    logic                      o_stall;
    logic                      o_valid;
    logic                      o_is_member;
    logic                      o_found;
    logic [INDEX_W-1:0]        o_member_index;
    logic                      o_error;
    logic [COUNT_W-1:0]        o_member_count;
    logic [MEMB_W-1:0]         o_membership;

    t_bitmap_mirror mirror;
    int             idle_max;
    int             quiet_cycles;

    bitmap_set_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_is_member    (o_is_member),
        .o_found        (o_found),
        .o_member_index (o_member_index),
        .o_error        (o_error),
        .o_member_count (o_member_count),
        .o_membership   (o_membership),
        .i_stall        (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Observe both channels at the clock edge and run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                mirror.note_op(i_kind, i_position);
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                mirror.check_status({o_is_member, o_found, o_member_index, o_error,
                                     o_member_count, o_membership});
            end
            if ((i_valid === 1'b1 && o_stall === 1'b0)
                || (o_valid === 1'b1 && i_stall === 1'b0)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: at random, raise the stall and hold it until after the next result has shown up.
    initial begin
        int hold;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            hold = $urandom_range(0, idle_max);
            if (hold == 0) begin
                i_stall <= 1'b0;
                do @(posedge i_clk); while (o_valid !== 1'b1);
            end else begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (o_valid !== 1'b1);
                repeat (hold - 1) @(posedge i_clk);
                i_stall <= 1'b0;
                do @(posedge i_clk); while (o_valid !== 1'b1);
            end
        end
    end

    // Present one operation after a random gap and hold it until accepted.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [POS_W-1:0] pos);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Hold off new operations until every pending result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly positions near a moving window, with negative and scattered ones mixed in.
    function automatic logic signed [POS_W-1:0] pick_position(int base);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            v = POS_BEFORE_FIRST;
        end else if (r < 12) begin
            v = -int'($urandom_range(2, 1024));
        end else if (r < 65) begin
            v = base + $urandom_range(0, 63);
        end else begin
            v = $urandom_range(0, CAPACITY - 1);
        end
        return v[POS_W-1:0];
    endfunction

    task automatic run_mix(int items, int base);
        int r;
        logic [KIND_W-1:0] kind;
        repeat (items) begin
            r = $urandom_range(0, 99);
            if (r < 32) kind = KIND_ADD;
            else if (r < 45) kind = KIND_DELETE;
            else if (r < 60) kind = KIND_TEST;
            else if (r < 71) kind = KIND_TAKE;
            else if (r < 92) kind = KIND_NEXT;
            else if (r < 95) kind = KIND_CLEAR;
            else kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
            send_op(kind, pick_position(base));
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Add every member in shuffled order, with lookups sprinkled in.
    task automatic fill_set();
        int order[CAPACITY];
        int j;
        int t;
        for (int i = 0; i < CAPACITY; i++) begin
            order[i] = i;
        end
        for (int i = CAPACITY - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            send_op(KIND_ADD, order[i][POS_W-1:0]);
            if (i % 32 == 31) begin
                send_op($urandom_range(0, 1) ? KIND_TEST : KIND_NEXT, pick_position(0));
            end
        end
    endtask

    initial begin
        mirror = new();
        idle_max = 10;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind <= KIND_ADD;
        i_position <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, edges of the range, errors and the odd cases.
        send_op(KIND_CLEAR, 0);
        send_op(KIND_TAKE, 0);
        send_op(KIND_NEXT, POS_BEFORE_FIRST);
        send_op(KIND_ADD, 0);
        send_op(KIND_ADD, 1023);
        send_op(KIND_ADD, 31);
        send_op(KIND_ADD, 32);
        send_op(KIND_ADD, 1023);
        send_op(KIND_TEST, 0);
        send_op(KIND_TEST, 1023);
        send_op(KIND_TEST, 5);
        send_op(KIND_TEST, -1);
        send_op(KIND_ADD, -1);
        send_op(KIND_DELETE, -1024);
        send_op(KIND_NEXT, POS_BEFORE_FIRST);
        send_op(KIND_NEXT, 0);
        send_op(KIND_NEXT, 32);
        // Searching past the last slot finds nothing.
        send_op(KIND_NEXT, 1023);
        // Starting below the start marker finds nothing and raises no error.
        send_op(KIND_NEXT, -2);
        send_op(KIND_NEXT, -1024);
        send_op(KIND_TAKE, 0);
        send_op(KIND_DELETE, 500);
        send_op(KIND_DELETE, 1023);
        send_op(KIND_SPARE_LO, 1023);
        send_op(KIND_SPARE_HI, -1);
        send_op(KIND_CLEAR, 0);
        wait_drained();

        // Random phases, one of them without any idling.
        run_mix(120, 0);
        idle_max = 0;
        run_mix(60, 480);
        idle_max = 10;
        wait_drained();

        // Fill to capacity, then work on the full set.
        fill_set();
        send_op(KIND_TEST, 1023);
        send_op(KIND_NEXT, 1022);
        send_op(KIND_TAKE, 0);
        send_op(KIND_NEXT, POS_BEFORE_FIRST);
        run_mix(60, 960);

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mirror.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
